// File: hw/rtl/dijet_leading_pair_asymmetry_macros.svh
// Assertion macros used by the back end of the dijet leading-pair asymmetry RTL.
`ifndef DIJET_LEADING_PAIR_ASYMMETRY_MACROS_SVH
`define DIJET_LEADING_PAIR_ASYMMETRY_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define DLA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the same cycle.
`define DLA_ASSERT_IMPL(label, cond, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dla_pkg.sv
// Package with types and constants of the dijet leading-pair asymmetry block.
package dla_pkg;

  localparam int unsigned DLA_PT_W    = 16;
  localparam int unsigned DLA_PHI_W   = 16;
  localparam int unsigned DLA_FRAC_W  = 17;
  localparam int unsigned DLA_CFG_IDX_W = 2;
  localparam int unsigned DLA_CFG_W   = 16;

  // Event queue between front and back.
  localparam int unsigned DLA_QDEPTH  = 2;
  localparam int unsigned DLA_QPTR_W  = $clog2(DLA_QDEPTH);
  localparam int unsigned DLA_QCNT_W  = $clog2(DLA_QDEPTH + 1);

  // Fraction bits produced by the divider after its first quotient bit.
  localparam int unsigned DLA_DIV_STEPS = DLA_FRAC_W - 1;
  localparam int unsigned DLA_DIV_CNT_W = $clog2(DLA_DIV_STEPS);

  // Configuration register indexes.
  localparam logic [DLA_CFG_IDX_W-1:0] CFG_LEAD_MIN_PT   = 2'd0;
  localparam logic [DLA_CFG_IDX_W-1:0] CFG_SUB_MIN_PT    = 2'd1;
  localparam logic [DLA_CFG_IDX_W-1:0] CFG_B2B_MIN_ANGLE = 2'd2;

  // Configuration reset values.
  localparam logic [DLA_CFG_W-1:0] LEAD_MIN_PT_RST   = 16'd160;
  localparam logic [DLA_CFG_W-1:0] SUB_MIN_PT_RST    = 16'd60;
  localparam logic [DLA_CFG_W-1:0] B2B_MIN_ANGLE_RST = 16'd28672;

  typedef struct packed {
    logic [DLA_PT_W-1:0]         jet_pt;
    logic signed [DLA_PHI_W-1:0] jet_phi;
    logic                        last_jet;
  } dla_jet_t;

  typedef struct packed {
    logic                        dijet_found;
    logic                        back_to_back;
    logic signed [DLA_PHI_W-1:0] delta_phi;
    logic [DLA_PHI_W-1:0]        abs_delta_phi;
    logic [DLA_FRAC_W-1:0]       asymmetry;
    logic [DLA_FRAC_W-1:0]       balance;
  } dla_result_t;

  typedef struct packed {
    logic [DLA_CFG_W-1:0] lead_min_pt;
    logic [DLA_CFG_W-1:0] sub_min_pt;
    logic [DLA_CFG_W-1:0] b2b_min_angle;
  } dla_cfg_t;

  // One classified event handed from front to back.
  typedef struct packed {
    logic                 found;
    logic                 b2b;
    logic [DLA_PHI_W-1:0] dphi;
    logic [DLA_PHI_W-1:0] adphi;
    logic [DLA_PT_W-1:0]  lead_pt;
    logic [DLA_PT_W-1:0]  sub_pt;
  } dla_pair_t;

endpackage

// File: hw/rtl/dijet_leading_pair_asymmetry.sv
// Dijet leading-pair asymmetry block: one jet per cycle in, one result per event out.
// The front end takes one jet per cycle whenever the two-entry event queue has room,
// keeping the leading and subleading jets and classifying the event on its last jet.
// The back end handles one event at a time and runs the shared divider only for a
// back-to-back dijet, first for the asymmetry and then for the balance. A held-off
// result stalls the back end in its emit state until the output register frees up.
// Results wait in an output register while the back end fetches the next event.
module dijet_leading_pair_asymmetry (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [dla_pkg::DLA_CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [dla_pkg::DLA_CFG_W-1:0]          cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  dla_pkg::dla_jet_t                      in_data_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output dla_pkg::dla_result_t                   out_data_o
);
  import dla_pkg::*;

  dla_cfg_t  cfg_q;
  dla_pair_t front_pair, q_pair;
  logic      push, pop, q_full, q_empty;

  assign cfg_ready_o = 1'b1;

  // Configuration registers; writes to an unused index are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.lead_min_pt   <= LEAD_MIN_PT_RST;
      cfg_q.sub_min_pt    <= SUB_MIN_PT_RST;
      cfg_q.b2b_min_angle <= B2B_MIN_ANGLE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_LEAD_MIN_PT:   cfg_q.lead_min_pt   <= cfg_data_i;
        CFG_SUB_MIN_PT:    cfg_q.sub_min_pt    <= cfg_data_i;
        CFG_B2B_MIN_ANGLE: cfg_q.b2b_min_angle <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dla_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .push_o     (push),
    .pair_o     (front_pair),
    .q_full_i   (q_full)
  );

  dla_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (front_pair),
    .full_o  (q_full),
    .pop_i   (pop),
    .empty_o (q_empty),
    .data_o  (q_pair)
  );

  dla_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .pair_i      (q_pair),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// File: hw/rtl/dla_front.sv
// Front end: tracks the leading and subleading jets and classifies each event.
module dla_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  dla_pkg::dla_cfg_t   cfg_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  dla_pkg::dla_jet_t   in_data_i,
  output logic                push_o,
  output dla_pkg::dla_pair_t  pair_o,
  input  logic                q_full_i
);
  import dla_pkg::*;

  logic [DLA_PT_W-1:0]  lead_pt_q, lead_pt_d, sub_pt_q, sub_pt_d;
  logic [DLA_PHI_W-1:0] lead_phi_q, lead_phi_d, sub_phi_q, sub_phi_d;
  logic                 lead_valid_q, lead_valid_d, sub_valid_q, sub_valid_d;
  logic [DLA_PT_W-1:0]  pt;
  logic [DLA_PHI_W-1:0] phi;
  logic                 take;
  logic                 found;
  logic [DLA_PHI_W-1:0] dphi, adphi;

  assign in_ready_o = !q_full_i;
  assign take       = in_valid_i && in_ready_o;
  assign pt         = in_data_i.jet_pt;
  assign phi        = $unsigned(in_data_i.jet_phi);

  // Pair update with the incoming jet; a tie with the leader falls to the subleader test.
  always_comb begin
    lead_pt_d    = lead_pt_q;
    lead_phi_d   = lead_phi_q;
    lead_valid_d = lead_valid_q;
    sub_pt_d     = sub_pt_q;
    sub_phi_d    = sub_phi_q;
    sub_valid_d  = sub_valid_q;
    if (!lead_valid_q || pt > lead_pt_q) begin
      sub_pt_d     = lead_pt_q;
      sub_phi_d    = lead_phi_q;
      sub_valid_d  = lead_valid_q;
      lead_pt_d    = pt;
      lead_phi_d   = phi;
      lead_valid_d = 1'b1;
    end else if (!sub_valid_q || pt > sub_pt_q) begin
      sub_pt_d    = pt;
      sub_phi_d   = phi;
      sub_valid_d = 1'b1;
    end
  end

  // Event classification on the updated pair.
  assign found = lead_valid_d && sub_valid_d &&
                 (lead_pt_d >= cfg_i.lead_min_pt) && (sub_pt_d >= cfg_i.sub_min_pt);
  assign dphi  = lead_phi_d - sub_phi_d;
  assign adphi = dphi[DLA_PHI_W-1] ? (DLA_PHI_W'(0) - dphi) : dphi;

  always_comb begin
    pair_o.found   = found;
    pair_o.b2b     = found && (adphi >= cfg_i.b2b_min_angle);
    pair_o.dphi    = found ? dphi : '0;
    pair_o.adphi   = found ? adphi : '0;
    pair_o.lead_pt = lead_pt_d;
    pair_o.sub_pt  = sub_pt_d;
  end

  assign push_o = take && in_data_i.last_jet;

  // Pair state; cleared after the last jet of an event.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_pt_q    <= '0;
      lead_phi_q   <= '0;
      lead_valid_q <= 1'b0;
      sub_pt_q     <= '0;
      sub_phi_q    <= '0;
      sub_valid_q  <= 1'b0;
    end else if (take) begin
      if (in_data_i.last_jet) begin
        lead_pt_q    <= '0;
        lead_phi_q   <= '0;
        lead_valid_q <= 1'b0;
        sub_pt_q     <= '0;
        sub_phi_q    <= '0;
        sub_valid_q  <= 1'b0;
      end else begin
        lead_pt_q    <= lead_pt_d;
        lead_phi_q   <= lead_phi_d;
        lead_valid_q <= lead_valid_d;
        sub_pt_q     <= sub_pt_d;
        sub_phi_q    <= sub_phi_d;
        sub_valid_q  <= sub_valid_d;
      end
    end
  end

endmodule

// File: hw/rtl/dla_fifo.sv
// Short queue of classified events between the front and back ends.
module dla_fifo (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  dla_pkg::dla_pair_t data_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output dla_pkg::dla_pair_t data_o
);
  import dla_pkg::*;

  dla_pair_t             slot_q [DLA_QDEPTH];
  logic [DLA_QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [DLA_QCNT_W-1:0] cnt_q;
  logic                  do_push, do_pop;

  assign full_o  = (cnt_q == DLA_QCNT_W'(DLA_QDEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = slot_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Storage slots.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == DLA_QPTR_W'(DLA_QDEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == DLA_QPTR_W'(DLA_QDEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// File: hw/rtl/dla_div.sv
// Radix-2 restoring divider for Q1.16 fractions whose dividend never exceeds the divisor.
module dla_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [dla_pkg::DLA_FRAC_W-1:0]   dividend_i,
  input  logic [dla_pkg::DLA_FRAC_W-1:0]   divisor_i,
  output logic                             done_o,
  output logic [dla_pkg::DLA_FRAC_W-1:0]   quot_o
);
  import dla_pkg::*;

  logic [DLA_FRAC_W-1:0]    rem_q, rem_d, div_q, quot_q, quot_d;
  logic [DLA_FRAC_W:0]      rem2;
  logic                     ge;
  logic                     busy_q, done_q, zero_q;
  logic [DLA_DIV_CNT_W-1:0] cnt_q;
  logic                     last_step;

  // One quotient bit per step: shift the remainder and try to subtract.
  assign rem2      = {rem_q, 1'b0};
  assign ge        = rem2 >= {1'b0, div_q};
  assign last_step = busy_q && (cnt_q == DLA_DIV_CNT_W'(DLA_DIV_STEPS - 1));

  always_comb begin
    if (start_i) begin
      // The integer quotient bit comes straight from one compare.
      if (dividend_i >= divisor_i) begin
        rem_d  = dividend_i - divisor_i;
        quot_d = DLA_FRAC_W'(1);
      end else begin
        rem_d  = dividend_i;
        quot_d = '0;
      end
    end else begin
      rem_d  = ge ? DLA_FRAC_W'(rem2 - {1'b0, div_q}) : rem2[DLA_FRAC_W-1:0];
      quot_d = {quot_q[DLA_FRAC_W-2:0], ge};
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (start_i || busy_q) begin
      rem_q  <= rem_d;
      quot_q <= quot_d;
    end
    if (start_i) begin
      div_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end
  end

  // Step control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= last_step;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  assign done_o = done_q;
  // A zero divisor yields a zero fraction.
  assign quot_o = zero_q ? '0 : quot_q;

endmodule

// File: hw/rtl/dla_back.sv
// Back end: computes the fractions of each queued event and holds the result register.
`include "dijet_leading_pair_asymmetry_macros.svh"

module dla_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 q_empty_i,
  input  dla_pkg::dla_pair_t   pair_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output dla_pkg::dla_result_t out_data_o
);
  import dla_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOAD = 5'b00010,
    S_ASYM = 5'b00100,
    S_BAL  = 5'b01000,
    S_EMIT = 5'b10000
  } back_state_e;

  back_state_e           state_q, state_d;
  dla_pair_t             rec_q;
  logic [DLA_FRAC_W-1:0] asym_q, bal_q;
  logic                  out_valid_q, out_valid_d;
  dla_result_t           out_q;
  logic                  div_start, div_done, out_load;
  logic [DLA_FRAC_W-1:0] div_x, div_d, div_quot;

  dla_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_x),
    .divisor_i  (div_d),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready_i);
  assign pop_o    = (state_q == S_IDLE) && !q_empty_i;

  // Sequencer: for a back-to-back event, asymmetry first, then balance, on the shared divider.
  always_comb begin
    state_d   = state_q;
    div_start = 1'b0;
    div_x     = {1'b0, rec_q.lead_pt - rec_q.sub_pt};
    div_d     = {1'b0, rec_q.lead_pt} + {1'b0, rec_q.sub_pt};
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          state_d = S_LOAD;
        end
      end
      S_LOAD: begin
        if (rec_q.b2b) begin
          div_start = 1'b1;
          state_d   = S_ASYM;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_ASYM: begin
        div_x = {1'b0, rec_q.sub_pt};
        div_d = {1'b0, rec_q.lead_pt};
        if (div_done) begin
          div_start = 1'b1;
          state_d   = S_BAL;
        end
      end
      S_BAL: begin
        if (div_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Event record and fraction registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      rec_q <= pair_i;
    end
    if ((state_q == S_ASYM) && div_done) begin
      asym_q <= div_quot;
    end
    if ((state_q == S_BAL) && div_done) begin
      bal_q <= div_quot;
    end
    if (out_load) begin
      out_q.dijet_found   <= rec_q.found;
      out_q.back_to_back  <= rec_q.b2b;
      out_q.delta_phi     <= $signed(rec_q.dphi);
      out_q.abs_delta_phi <= rec_q.adphi;
      out_q.asymmetry     <= rec_q.b2b ? asym_q : '0;
      out_q.balance       <= rec_q.b2b ? bal_q : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DLA_ASSERT_IMPL(a_start_state, div_start, (state_q == S_LOAD) || (state_q == S_ASYM),
                   "divider started outside the fraction states")
  `DLA_ASSERT_IMPL(a_pop_idle, pop_o, state_q == S_IDLE, "queue popped while busy")
  `DLA_ASSERT_IMPL(a_b2b_found, out_valid_q && out_q.back_to_back, out_q.dijet_found,
                   "back-to-back result without a dijet")
  `DLA_ASSERT_IMPL(a_frac_gated, out_valid_q && !out_q.back_to_back,
                   (out_q.asymmetry == '0) && (out_q.balance == '0),
                   "fractions set on an event that is not back to back")
  `DLA_ASSERT(a_bal_range, !out_valid_q || (out_q.balance <= 17'h10000),
              "balance above one")

endmodule

// File: bench/tb.sv
// Self-checking testbench for the dijet leading-pair asymmetry block.
`timescale 1ns / 100ps

module tb;
  import dla_pkg::*;

  // Index with no register behind it; writes to it must be ignored.
  localparam logic [DLA_CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  // Cycles the back end may still be busy after the last result of a phase.
  localparam int unsigned SETTLE_CYCLES = 60;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER_EVENTS = 25;
  localparam int unsigned QUIET_LIMIT = 3000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [DLA_CFG_IDX_W-1:0] cfg_index = '0;
  logic [DLA_CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  dla_jet_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  dla_result_t out_data;

  // Jets waiting to be offered, and per-event summaries still to come out.
  dla_jet_t jet_q[$];
  dla_result_t event_summaries[$];

  // Mirror of the cut registers.
  logic [DLA_CFG_W-1:0] lead_cut = LEAD_MIN_PT_RST;
  logic [DLA_CFG_W-1:0] sub_cut = SUB_MIN_PT_RST;
  logic [DLA_CFG_W-1:0] angle_cut = B2B_MIN_ANGLE_RST;

  // Leading and subleading jet of the event in progress.
  logic [DLA_PT_W-1:0] top_pt = '0;
  logic [DLA_PHI_W-1:0] top_phi = '0;
  logic top_seen = 1'b0;
  logic [DLA_PT_W-1:0] next_pt = '0;
  logic [DLA_PHI_W-1:0] next_phi = '0;
  logic next_seen = 1'b0;

  int unsigned mismatches = 0;
  int unsigned events_checked = 0;
  logic calm = 1'b0;

  dijet_leading_pair_asymmetry u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  initial begin : clock_gen
    forever #4 clk = ~clk;
  end

  // Gap length: mostly none, often short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Folds one jet into the leading pair and, on the last jet, predicts the event summary.
  task automatic fold_jet(input dla_jet_t j);
    dla_result_t r;
    logic [DLA_PHI_W-1:0] dphi;
    logic [DLA_PHI_W:0] span;
    logic [32:0] num;
    logic [32:0] den;
    if (!top_seen || j.jet_pt > top_pt) begin
      next_pt = top_pt;
      next_phi = top_phi;
      next_seen = top_seen;
      top_pt = j.jet_pt;
      top_phi = j.jet_phi;
      top_seen = 1'b1;
    end else if (!next_seen || j.jet_pt > next_pt) begin
      next_pt = j.jet_pt;
      next_phi = j.jet_phi;
      next_seen = 1'b1;
    end
    if (j.last_jet) begin
      r = '0;
      if (top_seen && next_seen && top_pt >= lead_cut && next_pt >= sub_cut) begin
        dphi = top_phi - next_phi;
        span = dphi[DLA_PHI_W-1] ? 17'h10000 - {1'b0, dphi} : {1'b0, dphi};
        r.dijet_found = 1'b1;
        r.delta_phi = dphi;
        r.abs_delta_phi = span[DLA_PHI_W-1:0];
        if (span >= {1'b0, angle_cut}) begin
          r.back_to_back = 1'b1;
          den = 33'(top_pt) + 33'(next_pt);
          if (den != 0) begin
            num = {1'b0, top_pt - next_pt, 16'h0000};
            r.asymmetry = 17'(num / den);
          end
          if (top_pt != 0) begin
            num = {1'b0, next_pt, 16'h0000};
            r.balance = 17'(num / 33'(top_pt));
          end
        end
      end
      event_summaries.push_back(r);
      top_pt = '0;
      top_phi = '0;
      top_seen = 1'b0;
      next_pt = '0;
      next_phi = '0;
      next_seen = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input logic [16:0] want,
                             input logic [16:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Long and calm stretches alternate with random idling.
  always @(posedge clk) begin : calm_select
    if ($urandom_range(0, 63) == 0) begin
      calm <= ($urandom_range(0, 3) == 0);
    end
  end

  // Jet driver: offers queued jets with random gaps and predicts each accepted transfer.
  always @(posedge clk or negedge rst_n) begin : jet_driver
    int unsigned gap_left;
    logic busy;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        fold_jet(in_data);
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (jet_q.size() != 0) begin
          in_data <= jet_q.pop_front();
          in_valid <= 1'b1;
          gap_left = calm ? 0 : pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each transfer and stalls the output at random.
  always @(posedge clk or negedge rst_n) begin : result_monitor
    int unsigned stall_left;
    int unsigned hold_left;
    logic held;
    logic rdy;
    dla_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
      hold_left = 0;
      held = 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (event_summaries.size() == 0) begin
          $error("result transfer with no event pending");
          mismatches++;
        end else begin
          want = event_summaries.pop_front();
          check_field("dijet_found", 17'(want.dijet_found), 17'(out_data.dijet_found));
          check_field("back_to_back", 17'(want.back_to_back), 17'(out_data.back_to_back));
          check_field("delta_phi", 17'(want.delta_phi), 17'(out_data.delta_phi));
          check_field("abs_delta_phi", 17'(want.abs_delta_phi),
                      17'(out_data.abs_delta_phi));
          check_field("asymmetry", want.asymmetry, out_data.asymmetry);
          check_field("balance", want.balance, out_data.balance);
        end
        events_checked++;
      end
      // Once in the run, hold the output off long enough to back up the input.
      if (hold_left != 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (!held && events_checked >= HOLD_AFTER_EVENTS) begin
        held = 1'b1;
        hold_left = HOLD_CYCLES;
        rdy = 1'b0;
      end else if (stall_left != 0) begin
        stall_left--;
        rdy = 1'b0;
      end else begin
        rdy = 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
      out_ready <= rdy;
    end
  end

  // Register mirror follows every configuration transfer.
  always @(posedge clk) begin : cut_mirror
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEAD_MIN_PT: begin
          lead_cut <= cfg_data;
        end
        CFG_SUB_MIN_PT: begin
          sub_cut <= cfg_data;
        end
        CFG_B2B_MIN_ANGLE: begin
          angle_cut <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  // Watchdog: ends the run when no transfer happens for too long.
  always @(posedge clk) begin : watchdog
    int unsigned quiet;
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
        || (cfg_valid && cfg_ready)) begin
      quiet = 0;
    end else begin
      quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  task automatic add_jet(input logic [15:0] pt, input logic [15:0] phi, input logic last);
    dla_jet_t j;
    j.jet_pt = pt;
    j.jet_phi = phi;
    j.last_jet = last;
    jet_q.push_back(j);
  endtask

  // One event with jets around an axis or opposite it, with ties and full-range values.
  task automatic add_event(input int unsigned n);
    logic [15:0] axis;
    logic [15:0] pt;
    logic [15:0] phi;
    logic [15:0] prev_pt;
    int unsigned r;
    axis = 16'($urandom);
    prev_pt = 16'($urandom_range(0, 600));
    for (int unsigned k = 0; k < n; k++) begin
      r = $urandom_range(0, 9);
      if (r < 6) pt = 16'($urandom_range(0, 600));
      else if (r < 8) pt = prev_pt;
      else pt = 16'($urandom);
      r = $urandom_range(0, 9);
      phi = 16'($urandom_range(0, 8191)) - 16'd4096;
      if (r < 4) phi = axis + phi;
      else if (r < 8) phi = axis + 16'h8000 + phi;
      else phi = 16'($urandom);
      add_jet(pt, phi, k == n - 1);
      prev_pt = pt;
    end
  endtask

  task automatic add_random_events(input int unsigned jets);
    int unsigned added;
    int unsigned n;
    int unsigned r;
    added = 0;
    while (added < jets) begin
      r = $urandom_range(0, 19);
      if (r == 0) n = 1;
      else if (r < 16) n = $urandom_range(2, 5);
      else if (r < 19) n = $urandom_range(6, 10);
      else n = $urandom_range(12, 16);
      add_event(n);
      added += n;
    end
  endtask

  // Waits until every jet is in and every summary is out, then lets the back end settle.
  task automatic wait_idle();
    do @(negedge clk); while (jet_q.size() != 0 || in_valid || event_summaries.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Must start on a rising edge; returns on the edge of the transfer with valid still high.
  task automatic write_reg(input logic [DLA_CFG_IDX_W-1:0] idx, input logic [15:0] value);
    cfg_index <= idx;
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic program_cuts(input logic [15:0] lead, input logic [15:0] sub,
                              input logic [15:0] angle);
    write_reg(CFG_LEAD_MIN_PT, lead);
    write_reg(CFG_SUB_MIN_PT, sub);
    write_reg(CFG_B2B_MIN_ANGLE, angle);
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset cuts: single jet, tie with the leader, angle wrap, values at and below the cuts.
    add_jet(16'hFFFF, 16'h8000, 1'b1);
    add_jet(16'd400, 16'h0000, 1'b0);
    add_jet(16'd200, 16'h8000, 1'b1);
    add_jet(16'd300, 16'd100, 1'b0);
    add_jet(16'd300, -16'sd30000, 1'b0);
    add_jet(16'd50, 16'd5, 1'b1);
    add_jet(16'd500, 16'h7FFF, 1'b0);
    add_jet(16'd200, 16'h8000, 1'b1);
    add_jet(16'd160, 16'd28672, 1'b0);
    add_jet(16'd60, 16'h0000, 1'b1);
    add_jet(16'd159, 16'h0000, 1'b0);
    add_jet(16'd60, 16'h8000, 1'b1);
    add_jet(16'd160, 16'h0000, 1'b0);
    add_jet(16'd59, 16'h8000, 1'b1);
    add_jet(16'd10, 16'd1000, 1'b0);
    add_jet(16'd20, -16'sd1000, 1'b0);
    add_jet(16'd300, -16'sd31000, 1'b1);
    add_random_events(100);
    wait_idle();

    // All cuts open: lone jet, zero denominators, zero subleader.
    write_reg(CFG_UNUSED_IDX, 16'hFFFF);
    program_cuts(16'd0, 16'd0, 16'd0);
    add_jet(16'd0, 16'h0000, 1'b1);
    add_jet(16'd0, 16'h0000, 1'b0);
    add_jet(16'd0, 16'h0000, 1'b1);
    add_jet(16'd0, 16'h1234, 1'b0);
    add_jet(16'd5, 16'h8765, 1'b1);
    add_random_events(90);
    wait_idle();

    // Tightest cuts: only full-scale pairs exactly opposite pass.
    program_cuts(16'hFFFF, 16'hFFFF, 16'h8000);
    add_jet(16'hFFFF, 16'd16384, 1'b0);
    add_jet(16'hFFFF, -16'sd16384, 1'b1);
    add_jet(16'hFFFF, 16'h0000, 1'b0);
    add_jet(16'hFFFE, 16'h0001, 1'b1);
    add_random_events(80);
    wait_idle();

    // Random cut settings.
    repeat (3) begin
      program_cuts(16'($urandom_range(0, 400)), 16'($urandom_range(0, 200)),
                   16'($urandom_range(0, 32768)));
      add_random_events(100);
      wait_idle();
    end

    @(negedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// File: dijet_leading_pair_asymmetry.f
+incdir+hw/rtl
hw/rtl/dla_pkg.sv
hw/rtl/dla_front.sv
hw/rtl/dla_fifo.sv
hw/rtl/dla_div.sv
hw/rtl/dla_back.sv
hw/rtl/dijet_leading_pair_asymmetry.sv
bench/tb.sv
